/* hw/rtl/pms_pkg.sv */
// ----------------------------------------------------------------------------
// pms_pkg
// Types, register indexes, microcode format and control store of the particle
// motion step block.
// ----------------------------------------------------------------------------
package pms_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRAVITY_X   = 3'd0,
        REG_GRAVITY_Y   = 3'd1,
        REG_GRAVITY_Z   = 3'd2,
        REG_LIFE_SPAN   = 3'd3,
        REG_DRAG_FACTOR = 3'd4,
        REG_DRAG_RATE   = 3'd5
    } cfg_reg_t;

    localparam logic        OP_TICK           = 1'b0;
    localparam logic        OP_LAUNCH         = 1'b1;
    localparam logic [23:0] LIFE_SPAN_RESET   = 24'd6553600;
    localparam logic [16:0] DRAG_FACTOR_RESET = 17'd65536;
    localparam logic [7:0]  DRAG_RATE_RESET   = 8'd30;
    localparam logic [23:0] AGE_MAX           = 24'hFFFFFF;
    localparam logic [1:0]  AXIS_LAST         = 2'd2;

    typedef struct packed {
        logic               opcode;
        logic [15:0]        delta_time;
        logic signed [31:0] start_px;
        logic signed [31:0] start_py;
        logic signed [31:0] start_pz;
        logic signed [31:0] start_vx;
        logic signed [31:0] start_vy;
        logic signed [31:0] start_vz;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic               alive;
        logic [23:0]        age;
    } out_item_t;

    // multiplier operand selects
    typedef enum logic [1:0] {MA_GRAV, MA_VEL, MA_AGE} mul_a_t;
    typedef enum logic [1:0] {MB_DT, MB_DRAG, MB_RATE} mul_b_t;

    // state write-back selects
    typedef enum logic [2:0] {
        WR_NONE, WR_VEL_ADD, WR_POS_ADD, WR_VEL_MUL, WR_AGE, WR_TARGET, WR_DRAG_INC
    } wr_sel_t;

    // sequencer jump conditions
    typedef enum logic [2:0] {
        JC_NEXT, JC_ALWAYS, JC_AXIS_MORE, JC_DRAG_DONE, JC_START, JC_EMIT
    } jump_t;

    typedef logic [3:0] upc_t;

    localparam upc_t UPC_START     = 4'd0;
    localparam upc_t UPC_MUL_G     = 4'd1;
    localparam upc_t UPC_DRAG_TEST = 4'd8;
    localparam upc_t UPC_DRAG_MUL  = 4'd9;
    localparam upc_t UPC_EMIT      = 4'd12;

    typedef struct packed {
        mul_a_t  mul_a;
        mul_b_t  mul_b;
        logic    mul_en;
        wr_sel_t wr;
        logic    axis_inc;
        jump_t   jump;
        upc_t    target;
    } ucode_t;

    // Control store. Fields: mul_a, mul_b, mul_en, wr, axis_inc, jump, target
    function automatic ucode_t ucode_rom(input upc_t pc);
        ucode_t uw;
        unique case (pc)
            // wait for a transfer; launch or dead tick go straight to output
            4'd0:    uw = '{MA_GRAV, MB_DT,   1'b0, WR_NONE,     1'b0, JC_START,  UPC_EMIT};
            4'd1:    uw = '{MA_GRAV, MB_DT,   1'b1, WR_NONE,     1'b0, JC_NEXT,   UPC_START};
            4'd2:    uw = '{MA_GRAV, MB_DT,   1'b0, WR_VEL_ADD,  1'b0, JC_NEXT,   UPC_START};
            4'd3:    uw = '{MA_VEL,  MB_DT,   1'b1, WR_NONE,     1'b0, JC_NEXT,   UPC_START};
            4'd4:    uw = '{MA_VEL,  MB_DT,   1'b0, WR_POS_ADD,  1'b1, JC_AXIS_MORE, UPC_MUL_G};
            4'd5:    uw = '{MA_GRAV, MB_DT,   1'b0, WR_AGE,      1'b0, JC_NEXT,   UPC_START};
            4'd6:    uw = '{MA_AGE,  MB_RATE, 1'b1, WR_NONE,     1'b0, JC_NEXT,   UPC_START};
            4'd7:    uw = '{MA_AGE,  MB_RATE, 1'b0, WR_TARGET,   1'b0, JC_NEXT,   UPC_START};
            4'd8:    uw = '{MA_GRAV, MB_DT,   1'b0, WR_NONE,     1'b0, JC_DRAG_DONE, UPC_EMIT};
            4'd9:    uw = '{MA_VEL,  MB_DRAG, 1'b1, WR_NONE,     1'b0, JC_NEXT,   UPC_START};
            4'd10:   uw = '{MA_VEL,  MB_DRAG, 1'b0, WR_VEL_MUL,  1'b1, JC_AXIS_MORE, UPC_DRAG_MUL};
            4'd11:   uw = '{MA_GRAV, MB_DT,   1'b0, WR_DRAG_INC, 1'b0, JC_ALWAYS, UPC_DRAG_TEST};
            4'd12:   uw = '{MA_GRAV, MB_DT,   1'b0, WR_NONE,     1'b0, JC_EMIT,   UPC_START};
            default: uw = '{MA_GRAV, MB_DT,   1'b0, WR_NONE,     1'b0, JC_ALWAYS, UPC_START};
        endcase
        return uw;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -35'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/particle_motion_step_top.sv */
// ----------------------------------------------------------------------------
// particle_motion_step_top
// Fixed-point semi-implicit Euler step of one 3-D particle, run by a small
// microcoded sequencer around one shared 32x17 multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry items in; each item gives exactly one result
//   on m_valid/m_ready/m_data. Configuration is written through cfg_wr_en,
//   cfg_index and cfg_wdata, one register per cycle. The user writes it only
//   while the block is idle; the block itself does not enforce this.
// Steps: a launch, or a tick on a dead particle, goes straight to output;
//   a tick on a live particle updates velocity then position per axis, then
//   age and drag target, then applies drag until the count reaches it.
//   Every product goes through the single multiplier, one axis at a time,
//   with its result registered before the add and saturate step.
//   A new item is taken as soon as the sequencer is back at its wait step,
//   even while the previous result is still held on m_data.
// Stall: if the previous result has not been taken, the sequencer holds at
//   its output step until m_ready, so nothing is dropped.
// Reset (aresetn low, synchronous): state cleared, particle alive, registers
//   back to their defaults, no result pending.
// ----------------------------------------------------------------------------
module particle_motion_step_top
    import pms_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,

    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // configuration
    logic signed [31:0] grav_reg [3];
    logic [23:0]        life_span_reg;
    logic [16:0]        drag_factor_reg;
    logic [7:0]         drag_rate_reg;

    // particle state
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] pos_next [3];
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] vel_next [3];
    logic [23:0]        age_reg, age_next;
    logic [15:0]        drag_count_reg, drag_count_next;
    logic               live_reg, live_next;

    // sequencer and datapath
    upc_t               upc_reg, upc_next;
    logic [1:0]         axis_reg, axis_next;
    logic [15:0]        dt_reg, dt_next;
    logic [15:0]        target_reg, target_next;
    logic signed [48:0] prod_reg, prod_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;

    ucode_t             uw;
    logic               s_accept;
    logic               emit_go;
    logic signed [31:0] mul_a;
    logic [16:0]        mul_b;
    logic signed [49:0] prod_full;
    logic signed [32:0] prod_floor;
    logic [24:0]        age_sum;
    logic [23:0]        age_sat;
    logic [32:0]        tgt_sum;

    assign uw       = ucode_rom(upc_reg);
    assign s_ready  = (uw.jump == JC_START);
    assign s_accept = s_valid && s_ready;
    assign emit_go  = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // shared multiplier
    always_comb begin
        unique case (uw.mul_a)
            MA_GRAV: mul_a = grav_reg[axis_reg];
            MA_VEL:  mul_a = vel_reg[axis_reg];
            MA_AGE:  mul_a = $signed({8'd0, age_reg});
            default: mul_a = '0;
        endcase
        unique case (uw.mul_b)
            MB_DT:   mul_b = {1'b0, dt_reg};
            MB_DRAG: mul_b = drag_factor_reg;
            MB_RATE: mul_b = {9'd0, drag_rate_reg};
            default: mul_b = '0;
        endcase
    end

    assign prod_full  = mul_a * $signed({1'b0, mul_b});
    assign prod_floor = prod_reg[48:16];   // arithmetic shift is floor
    assign age_sum    = {1'b0, age_reg} + {9'd0, dt_reg};
    assign age_sat    = age_sum[24] ? AGE_MAX : age_sum[23:0];
    assign tgt_sum    = {1'b0, prod_reg[31:0]} + 33'd65535;

    always_comb begin
        pos_next        = pos_reg;
        vel_next        = vel_reg;
        age_next        = age_reg;
        drag_count_next = drag_count_reg;
        live_next       = live_reg;
        axis_next       = axis_reg;
        dt_next         = dt_reg;
        target_next     = target_reg;
        prod_next       = prod_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        upc_next        = upc_reg;

        if (uw.mul_en) begin
            prod_next = prod_full[48:0];
        end

        if (s_accept) begin
            dt_next = s_data.delta_time;
            if (s_data.opcode == OP_LAUNCH) begin
                pos_next[0]     = s_data.start_px;
                pos_next[1]     = s_data.start_py;
                pos_next[2]     = s_data.start_pz;
                vel_next[0]     = s_data.start_vx;
                vel_next[1]     = s_data.start_vy;
                vel_next[2]     = s_data.start_vz;
                age_next        = '0;
                drag_count_next = '0;
                live_next       = 1'b1;
            end
        end

        unique case (uw.wr)
            WR_NONE: ;
            WR_VEL_ADD: vel_next[axis_reg] = sat32({{3{vel_reg[axis_reg][31]}},
                                                   vel_reg[axis_reg]}
                                                  + {{2{prod_floor[32]}}, prod_floor});
            WR_POS_ADD: pos_next[axis_reg] = sat32({{3{pos_reg[axis_reg][31]}},
                                                   pos_reg[axis_reg]}
                                                  + {{2{prod_floor[32]}}, prod_floor});
            WR_VEL_MUL: vel_next[axis_reg] = sat32({{2{prod_floor[32]}}, prod_floor});
            WR_AGE: begin
                age_next  = age_sat;
                live_next = (age_sat < life_span_reg);
            end
            WR_TARGET:   target_next     = tgt_sum[31:16];
            WR_DRAG_INC: drag_count_next = drag_count_reg + 16'd1;
            default: ;
        endcase

        if (uw.axis_inc) begin
            axis_next = (axis_reg == AXIS_LAST) ? 2'd0 : axis_reg + 2'd1;
        end

        unique case (uw.jump)
            JC_NEXT:      upc_next = upc_reg + 4'd1;
            JC_ALWAYS:    upc_next = uw.target;
            JC_AXIS_MORE: upc_next = (axis_reg != AXIS_LAST) ? uw.target : upc_reg + 4'd1;
            JC_DRAG_DONE: upc_next = (drag_count_reg >= target_reg) ? uw.target
                                                                     : upc_reg + 4'd1;
            JC_START: begin
                if (s_accept) begin
                    upc_next = (s_data.opcode == OP_LAUNCH || !live_reg) ? uw.target
                                                                          : upc_reg + 4'd1;
                end
            end
            JC_EMIT: begin
                if (emit_go) begin
                    upc_next     = uw.target;
                    m_valid_next = 1'b1;
                    m_data_next  = '{pos_x: pos_reg[0], pos_y: pos_reg[1], pos_z: pos_reg[2],
                                     vel_x: vel_reg[0], vel_y: vel_reg[1], vel_z: vel_reg[2],
                                     alive: live_reg, age: age_reg};
                end
            end
            default: upc_next = UPC_START;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg         <= UPC_START;
            axis_reg        <= '0;
            m_valid_reg     <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                pos_reg[i]  <= '0;
                vel_reg[i]  <= '0;
                grav_reg[i] <= '0;
            end
            age_reg         <= '0;
            drag_count_reg  <= '0;
            live_reg        <= 1'b1;
            life_span_reg   <= LIFE_SPAN_RESET;
            drag_factor_reg <= DRAG_FACTOR_RESET;
            drag_rate_reg   <= DRAG_RATE_RESET;
        end else begin
            upc_reg        <= upc_next;
            axis_reg       <= axis_next;
            m_valid_reg    <= m_valid_next;
            pos_reg        <= pos_next;
            vel_reg        <= vel_next;
            age_reg        <= age_next;
            drag_count_reg <= drag_count_next;
            live_reg       <= live_next;
            if (cfg_wr_en) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_GRAVITY_X:   grav_reg[0]     <= $signed(cfg_wdata);
                    REG_GRAVITY_Y:   grav_reg[1]     <= $signed(cfg_wdata);
                    REG_GRAVITY_Z:   grav_reg[2]     <= $signed(cfg_wdata);
                    REG_LIFE_SPAN:   life_span_reg   <= cfg_wdata[23:0];
                    REG_DRAG_FACTOR: drag_factor_reg <= cfg_wdata[16:0];
                    REG_DRAG_RATE:   drag_rate_reg   <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        dt_reg     <= dt_next;
        target_reg <= target_next;
        prod_reg   <= prod_next;
        m_data_reg <= m_data_next;
    end

endmodule

/* hw/rtl/pms_checker.sv */
// ----------------------------------------------------------------------------
// pms_checker
// Port-level checks of the particle motion step block, bound to the top level.
// ----------------------------------------------------------------------------
module pms_checker
    import pms_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one item at a time: no transfer in the cycle after a transfer
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in progress");

    // launch with an empty output shows the launch state as the next result
    a_launch: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.opcode == OP_LAUNCH) && !m_valid |->
        ##2 (m_valid && m_data.alive && (m_data.age == 24'd0)
             && (m_data.pos_x == $past(s_data.start_px, 2))
             && (m_data.vel_z == $past(s_data.start_vz, 2))))
        else $error("launch result wrong");

endmodule

bind particle_motion_step_top pms_checker u_pms_checker (.*);

/* tb/particle_motion_step_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_motion_step_top_tb
// Self-checking bench for the particle motion step block. Items go in over
// the valid/ready input channel and every returned state is compared field
// by field against a fixed-point predictor of the integrator. A directed part
// hits saturation, death, revival, lowered drag rate and drag above unity.
// Random flights follow under changing register settings, with random
// stalls on both sides and a long elapsed-time run up to saturation.
// ----------------------------------------------------------------------------
module particle_motion_step_top_tb;
    import pms_pkg::*;

    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int HOLD_CYCLES = 400;

    class flight_scoreboard;
        logic signed [31:0] grav [3];
        logic [23:0]        life;
        logic [16:0]        drag_mul;
        logic [7:0]         drag_per_s;
        logic signed [31:0] pos [3];
        logic signed [31:0] vel [3];
        logic [23:0]        age;
        logic [15:0]        drag_done;
        logic               alive;
        out_item_t          want_states [$];
        int                 mismatches, compared, launches, live_ticks, dead_ticks;
        int                 drag_steps;

        function new();
            for (int i = 0; i < 3; i++) begin
                grav[i] = '0;
                pos[i]  = '0;
                vel[i]  = '0;
            end
            life       = LIFE_SPAN_RESET;
            drag_mul   = DRAG_FACTOR_RESET;
            drag_per_s = DRAG_RATE_RESET;
            age        = '0;
            drag_done  = '0;
            alive      = 1'b1;
        endfunction

        // floor(a*b / 2^16)
        function longint floor_q16(longint a, longint b);
            return (a * b) >>> 16;
        endfunction

        function logic signed [31:0] clamp32(longint v);
            if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[31:0];
        endfunction

        function void set_reg(cfg_reg_t idx, logic [31:0] val);
            case (idx)
                REG_GRAVITY_X:   grav[0] = val;
                REG_GRAVITY_Y:   grav[1] = val;
                REG_GRAVITY_Z:   grav[2] = val;
                REG_LIFE_SPAN:   life = val[23:0];
                REG_DRAG_FACTOR: drag_mul = val[16:0];
                REG_DRAG_RATE:   drag_per_s = val[7:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return want_states.size();
        endfunction

        function void advance_particle(in_item_t it);
            longint    t;
            out_item_t st;
            if (it.opcode == OP_LAUNCH) begin
                pos[0] = it.start_px;
                pos[1] = it.start_py;
                pos[2] = it.start_pz;
                vel[0] = it.start_vx;
                vel[1] = it.start_vy;
                vel[2] = it.start_vz;
                age       = '0;
                drag_done = '0;
                alive     = 1'b1;
                launches++;
            end else if (alive) begin
                live_ticks++;
                // new velocity feeds the position update
                for (int i = 0; i < 3; i++) begin
                    vel[i] = clamp32(vel[i] + floor_q16(grav[i], it.delta_time));
                    pos[i] = clamp32(pos[i] + floor_q16(vel[i], it.delta_time));
                end
                t = longint'(age) + longint'(it.delta_time);
                age = (t > longint'(AGE_MAX)) ? AGE_MAX : t[23:0];
                if (age >= life) alive = 1'b0;
                // drag still applies on the tick that kills the particle
                t = (longint'(age) * longint'(drag_per_s) + 65535) >>> 16;
                while (longint'(drag_done) < t) begin
                    for (int i = 0; i < 3; i++) vel[i] = clamp32(floor_q16(vel[i], drag_mul));
                    drag_done++;
                    drag_steps++;
                end
            end else begin
                dead_ticks++;
            end
            st.pos_x = pos[0];
            st.pos_y = pos[1];
            st.pos_z = pos[2];
            st.vel_x = vel[0];
            st.vel_y = vel[1];
            st.vel_z = vel[2];
            st.alive = alive;
            st.age   = age;
            want_states.push_back(st);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("%0t mismatch: %s", $realtime, msg);
        endtask

        task cmp_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s: got %h, want %h",
                                          compared, name, got, want));
        endtask

        task check_state(out_item_t got);
            out_item_t want;
            if (want_states.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: %h", got));
                return;
            end
            want = want_states.pop_front();
            compared++;
            cmp_field("pos_x", got.pos_x, want.pos_x);
            cmp_field("pos_y", got.pos_y, want.pos_y);
            cmp_field("pos_z", got.pos_z, want.pos_z);
            cmp_field("vel_x", got.vel_x, want.vel_x);
            cmp_field("vel_y", got.vel_y, want.vel_y);
            cmp_field("vel_z", got.vel_z, want.vel_z);
            cmp_field("alive", got.alive, want.alive);
            cmp_field("age", got.age, want.age);
        endtask
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    flight_scoreboard sb;
    bit               steady;
    bit               hold_req;
    int               cycles;
    int               settings_used;
    int               dt_hi = 65535;

    particle_motion_step_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // transfer monitor: predict on input, compare on output
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.advance_particle(s_data);
            if (m_valid && m_ready) sb.check_state(m_data);
        end
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (steady) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 29);
            end
        end
    end

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(9))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2, 3:    return $urandom;
            default: return $signed($urandom_range(33554431)) - 32'sd16777216;
        endcase
    endfunction

    function automatic logic [15:0] rand_dt();
        int r;
        r = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 10) return 16'(dt_hi);
        if (r < 50) return 16'($urandom_range(dt_hi));
        return 16'($urandom_range(4095));
    endfunction

    function automatic in_item_t launch_item(logic signed [31:0] px, py, pz, vx, vy, vz);
        in_item_t it;
        it.opcode     = OP_LAUNCH;
        it.delta_time = 16'($urandom);
        it.start_px   = px;
        it.start_py   = py;
        it.start_pz   = pz;
        it.start_vx   = vx;
        it.start_vy   = vy;
        it.start_vz   = vz;
        return it;
    endfunction

    function automatic in_item_t random_launch();
        return launch_item(rand_coord(), rand_coord(), rand_coord(),
                           rand_coord(), rand_coord(), rand_coord());
    endfunction

    // start fields carry junk on a tick
    function automatic in_item_t tick_item(logic [15:0] dt);
        in_item_t it;
        it.opcode     = OP_TICK;
        it.delta_time = dt;
        it.start_px   = $urandom;
        it.start_py   = $urandom;
        it.start_pz   = $urandom;
        it.start_vx   = $urandom;
        it.start_vy   = $urandom;
        it.start_vz   = $urandom;
        return it;
    endfunction

    task automatic send_item(in_item_t it);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        if (!steady) begin
            while ($urandom_range(99) < 29) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
    endtask

    // step past the current edge first so the monitor has logged the last transfer
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_setup(logic [31:0] gx, gy, gz, logic [23:0] life,
                               logic [16:0] factor, logic [7:0] rate);
        write_reg(REG_GRAVITY_X, gx);
        write_reg(REG_GRAVITY_Y, gy);
        write_reg(REG_GRAVITY_Z, gz);
        write_reg(REG_LIFE_SPAN, 32'(life));
        write_reg(REG_DRAG_FACTOR, 32'(factor));
        write_reg(REG_DRAG_RATE, 32'(rate));
        settings_used++;
        // keep drag work per tick bounded at high rates
        dt_hi = (rate > 63) ? 16383 : 65535;
    endtask

    task automatic random_setup(bit heavy);
        logic [31:0] g [3];
        logic [23:0] life;
        logic [16:0] factor;
        logic [7:0]  rate;
        for (int a = 0; a < 3; a++) begin
            case ($urandom_range(7))
                0:       g[a] = 32'h7FFFFFFF;
                1:       g[a] = 32'h80000000;
                2:       g[a] = $urandom;
                3:       g[a] = '0;
                default: g[a] = $signed($urandom_range(2097151)) - 32'sd1048576;
            endcase
        end
        case ($urandom_range(9))
            0:       life = '0;
            1:       life = AGE_MAX;
            2:       life = 24'($urandom);
            default: life = 24'($urandom_range(24'h0A0000));
        endcase
        case ($urandom_range(7))
            0:       factor = '0;
            1:       factor = 17'($urandom_range(17'h1FFFF, 17'h10001));
            2, 3:    factor = DRAG_FACTOR_RESET;
            default: factor = 17'($urandom_range(17'h10000, 17'h0C000));
        endcase
        case ($urandom_range(3))
            0:       rate = 8'd0;
            1:       rate = 8'd1;
            2:       rate = DRAG_RATE_RESET;
            default: rate = 8'($urandom_range(63));
        endcase
        if (heavy) rate = 8'd255;
        apply_setup(g[0], g[1], g[2], life, factor, rate);
    endtask

    // mostly launch-then-ticks flights, with some stray items in between
    task automatic run_flights(int n);
        int       sent_here;
        int       len;
        in_item_t stray;
        send_item(random_launch());
        sent_here = 1;
        while (sent_here < n) begin
            case ($urandom_range(19))
                0: begin
                    stray = tick_item(rand_dt());
                    stray.opcode = 1'($urandom_range(1));
                    send_item(stray);
                    sent_here++;
                end
                1: begin
                    send_item(tick_item($urandom_range(1) ? 16'hFFFF : 16'h0000));
                    sent_here++;
                end
                default: begin
                    len = $urandom_range(40, 1);
                    send_item(random_launch());
                    repeat (len) send_item(tick_item(rand_dt()));
                    sent_here += len + 1;
                end
            endcase
        end
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default registers: tick from reset state, then saturating launch
        send_item(tick_item(16'hFFFF));
        send_item(launch_item(32'sh7FFFFFFF, 32'sh80000000, 32'sd0,
                              32'sh7FFFFFFF, 32'sh80000000, 32'sd1));
        send_item(tick_item(16'hFFFF));
        send_item(tick_item(16'h0000));
        send_item(tick_item(16'h0001));

        // extreme gravity, 3 s life, drag above unity at full rate
        wait_drained();
        apply_setup(32'h7FFFFFFF, 32'h80000000, 32'h00010000, 24'h030000,
                    17'h1FFFF, 8'd255);
        send_item(launch_item(32'sd0, 32'sd0, 32'sd0, 32'sd256, -32'sd256, 32'sd0));
        repeat (4) send_item(tick_item(16'hFFFF));
        send_item(tick_item(16'hFFFF));
        send_item(random_launch());

        // zero life and zero drag factor: dies on first tick, velocity wiped
        wait_drained();
        apply_setup('0, '0, '0, 24'h000000, 17'h00000, 8'd1);
        send_item(tick_item(16'd100));
        send_item(tick_item(16'd100));
        send_item(launch_item(32'sd65536, -32'sd65536, 32'sd0,
                              32'sd327680, 32'sd655360, -32'sd131072));

        // run drag up, then lower the rate so the target falls behind
        wait_drained();
        apply_setup(-32'sd32768, 32'sd16384, -32'sd642908, AGE_MAX, 17'h0F000, 8'd200);
        send_item(tick_item(16'hFFFF));
        send_item(tick_item(16'hFFFF));
        wait_drained();
        write_reg(REG_DRAG_RATE, 32'd10);
        sb.set_reg(REG_DRAG_RATE, 32'd10);
        send_item(tick_item(16'd100));
        send_item(tick_item(16'hFFFF));

        for (int p = 0; p < 7; p++) begin
            wait_drained();
            random_setup(p == 5);
            steady = (p == 2);
            if (p == 4) begin
                run_flights(64);
                hold_req = 1'b1;
                run_flights(64);
            end else begin
                run_flights(128);
            end
        end
        steady = 1'b0;

        // long flight: elapsed time runs into saturation
        wait_drained();
        apply_setup(32'h00002000, 32'hFFFFE000, '0, AGE_MAX, 17'h0FFFF, 8'd1);
        send_item(random_launch());
        repeat (280) send_item(tick_item(16'($urandom_range(65535, 60000))));

        wait_drained();
        repeat (40) @(posedge aclk);

        $display("Run covered %0d launches, %0d live ticks, %0d dead ticks,",
                 sb.launches, sb.live_ticks, sb.dead_ticks);
        $display("%0d drag steps over %0d register settings; %0d results compared.",
                 sb.drag_steps, settings_used, sb.compared);
        if (sb.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
